// ----- sv/bsis_pkg.sv -----
// Package with the item types, operation codes and defaults of the sorted identifier set.
`timescale 1ns / 1ps
package bsis_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_WIDTH_DEF = 16;
  localparam int ID_IN_W      = 16;
  localparam int OP_W         = 2;
  localparam int COUNT_OUT_W  = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ID_IN_W-1:0] id;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic                   changed;
    logic [COUNT_OUT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

// ----- sv/bsis_cell.sv -----
// One cell of the sorted chain: holds one identifier and shifts it up or down on command.
`timescale 1ns / 1ps
module bsis_cell
  import bsis_pkg::*;
#(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [ID_WIDTH-1:0] key,
  input  logic                occupied,
  input  logic                left_ge,
  input  logic [ID_WIDTH-1:0] left_id,
  input  logic [ID_WIDTH-1:0] right_id,
  output logic [ID_WIDTH-1:0] id_r,
  output logic                ge,
  output logic                eq
);

  logic [ID_WIDTH-1:0] id_nxt;

  // An empty cell counts as not less than the key, so it lies at or after the lower bound.
  assign ge = !(occupied && (id_r < key));
  assign eq = occupied && (id_r == key);

  always_comb begin
    id_nxt = id_r;
    if (ctl.ins_en && ge) begin
      id_nxt = left_ge ? left_id : key;
    end else if (ctl.del_en && ge) begin
      id_nxt = right_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

// ----- sv/bounded_sorted_id_set_unit.sv -----
// Top level of the bounded sorted identifier set: a chain of compare-and-shift cells.
//
//   port group   direction  handshake                 payload
//   in_          input      start high and busy low   in_item  (operation, id)
//   out_         output     out_strobe, one cycle     out_item (found, changed, count)
//
// Every cell compares its identifier with the key in the cycle an item is taken, and the
// cells from the key's place on shift up or down then, so one item is taken every cycle.
// The result is registered and shows in the next cycle, for one cycle; busy stays low.
// Reset empties the set at once by clearing the count; the cells need no clearing.
// The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps
module bounded_sorted_id_set_unit
  import bsis_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_strobe_r;
  out_item_t           out_item_r;
  out_item_t           out_item_nxt;
  logic                accept;
  logic [ID_WIDTH-1:0] key;
  logic                found;
  logic                full;
  cell_ctl_t           ctl;
  logic [ID_WIDTH-1:0] cell_id [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_eq;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign key    = ID_WIDTH'(in_item.id);
  assign found  = |cell_eq;
  assign full   = (count_r == CNT_W'(CAPACITY));

  assign ctl.ins_en = accept && (in_item.operation == OP_INSERT) && !full;
  assign ctl.del_en = accept && (in_item.operation == OP_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bsis_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (key),
      .occupied (CNT_W'(i) < count_r),
      .left_ge  ((i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i - 1]),
      .left_id  (cell_id[(i == 0) ? 0 : i - 1]),
      .right_id (cell_id[(i == CAPACITY - 1) ? i : i + 1]),
      .id_r     (cell_id[i]),
      .ge       (cell_ge[i]),
      .eq       (cell_eq[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_item_nxt.found   = found;
    out_item_nxt.changed = ctl.ins_en || ctl.del_en;
    out_item_nxt.count   = COUNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("An accepted item produced no result.");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)) && out_item.changed)
    else $error("An insert did not add one entry.");

  a_remove_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del_en |=> (count_r == $past(count_r) - CNT_W'(1)) && out_item.found)
    else $error("A remove did not delete one entry.");

  a_full_no_insert : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (in_item.operation == OP_INSERT)) |=> !out_item.changed)
    else $error("An insert changed a full store.");

endmodule

// ----- tb/tb_bounded_sorted_id_set_unit.sv -----
// Self-checking testbench for the bounded sorted identifier set: directed table, then random phases.
`timescale 1ns / 1ps
module tb_bounded_sorted_id_set_unit;
  import bsis_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [ID_IN_W-1:0]     id;
    bit                     pinned;
    logic                   found;
    logic                   changed;
    logic [COUNT_OUT_W-1:0] count;
  } directed_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  bit        pinned_valid = 1'b0;
  out_item_t pinned_result = '0;

  logic [ID_IN_W-1:0] held_ids[$];
  out_item_t          pending_results[$];
  int                 error_count = 0;

  directed_row_t directed_rows[20] = '{
    '{OP_QUERY,  16'h0000, 1'b1, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'h1234, 1'b1, 1'b0, 1'b0, 6'd0},
    '{OP_SPARE,  16'hFFFF, 1'b1, 1'b0, 1'b0, 6'd0},
    '{OP_INSERT, 16'h0000, 1'b1, 1'b0, 1'b1, 6'd1},
    '{OP_INSERT, 16'hFFFF, 1'b1, 1'b0, 1'b1, 6'd2},
    '{OP_INSERT, 16'h0000, 1'b1, 1'b1, 1'b1, 6'd3},
    '{OP_QUERY,  16'hFFFF, 1'b1, 1'b1, 1'b0, 6'd3},
    '{OP_SPARE,  16'h0000, 1'b1, 1'b1, 1'b0, 6'd3},
    '{OP_INSERT, 16'h8000, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_INSERT, 16'h7FFF, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_INSERT, 16'h5555, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_INSERT, 16'hAAAA, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_QUERY,  16'h8000, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'h7FFF, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'h7FFF, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'h0000, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'h0000, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'h0000, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_REMOVE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OP_QUERY,  16'hAAAA, 1'b0, 1'b0, 1'b0, 6'd0}
  };

  bounded_sorted_id_set_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t apply_set_op(in_item_t item);
    int        pos;
    bit        hit;
    out_item_t res;
    pos = 0;
    while (pos < held_ids.size() && held_ids[pos] < item.id) pos++;
    hit = (pos < held_ids.size()) && (held_ids[pos] == item.id);
    res = '0;
    res.found = hit;
    case (item.operation)
      OP_INSERT: begin
        if (held_ids.size() < CAPACITY_DEF) begin
          held_ids.insert(pos, item.id);
          res.changed = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          held_ids.delete(pos);
          res.changed = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = COUNT_OUT_W'(held_ids.size());
    return res;
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && start && !busy) begin
      want = apply_set_op(in_item);
      if (pinned_valid) want = pinned_result;
      pending_results = {pending_results, want};
    end
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, got %0b", $time, want.found,
                   out_item.found);
          error_count++;
        end
        if (out_item.changed !== want.changed) begin
          $display("%0t: changed mismatch, expected %0b, got %0b", $time, want.changed,
                   out_item.changed);
          error_count++;
        end
        if (out_item.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d", $time, want.count,
                   out_item.count);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_IN_W-1:0] id,
                           input bit pin, input out_item_t want, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{operation: op, id: id};
    pinned_valid <= pin;
    pinned_result <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int                 idle_by_phase[NUM_PHASES];
    logic [ID_IN_W-1:0] id_pool[8];
    int                 ins_w;
    int                 rem_w;
    int                 r;
    logic [OP_W-1:0]    op;
    logic [ID_IN_W-1:0] id;
    out_item_t          want;

    idle_by_phase = '{0, 88, 27, 0, 88, 27, 0, 27};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      want = '{found: directed_rows[i].found, changed: directed_rows[i].changed,
               count: directed_rows[i].count};
      send_item(directed_rows[i].op, directed_rows[i].id, directed_rows[i].pinned, want, 0);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 3)
        0: begin ins_w = 70; rem_w = 10; end
        1: begin ins_w = 40; rem_w = 40; end
        default: begin ins_w = 15; rem_w = 65; end
      endcase
      foreach (id_pool[k])
        id_pool[k] = ($urandom_range(7) == 0) ? (k[0] ? 16'hFFFF : 16'h0000) : 16'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < ins_w) op = OP_INSERT;
        else if (r < ins_w + rem_w) op = OP_REMOVE;
        else if (r < 95) op = OP_QUERY;
        else op = OP_SPARE;
        if ($urandom_range(9) < 7) id = id_pool[$urandom_range(7)];
        else id = 16'($urandom);
        send_item(op, id, 1'b0, '0, idle_by_phase[p]);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("** bounded_sorted_id_set_unit: PASSED **");
    else
      $display("** bounded_sorted_id_set_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("** bounded_sorted_id_set_unit: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bsis_pkg.sv
sv/bsis_cell.sv
sv/bounded_sorted_id_set_unit.sv
tb/tb_bounded_sorted_id_set_unit.sv
